/* design/mrc_pkg.sv */
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared types, constants and the CRC-16/MODBUS byte update for the Modbus
// RTU response checker.
// ----------------------------------------------------------------------------
package mrc_pkg;

    // CRC-16/MODBUS: reflected polynomial, all-ones start value.
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Expected header bytes of a read reply.
    localparam logic [7:0] HDR_SLAVE       = 8'h01;
    localparam logic [7:0] HDR_FUNC        = 8'h03;
    localparam logic [7:0] HDR_COUNT_KIND0 = 8'h02;
    localparam logic [7:0] HDR_COUNT_KIND1 = 8'h04;

    // Byte positions within a frame.
    localparam logic [3:0] IDX_SLAVE   = 4'd0;
    localparam logic [3:0] IDX_FUNC    = 4'd1;
    localparam logic [3:0] IDX_COUNT   = 4'd2;
    localparam logic [3:0] IDX_DATA0   = 4'd3;
    localparam logic [3:0] IDX_DATA1   = 4'd4;
    localparam logic [3:0] IDX_DATA2   = 4'd5;
    localparam logic [3:0] IDX_DATA3   = 4'd6;
    localparam logic [3:0] IDX_MAX     = 4'd15;

    // Payload length (header plus data) for each request kind.
    localparam logic [3:0] PAYLOAD_KIND0 = 4'd5;
    localparam logic [3:0] PAYLOAD_KIND1 = 4'd7;

    typedef enum logic [1:0] {
        STATUS_VALID  = 2'd0,
        STATUS_SHORT  = 2'd1,
        STATUS_HEADER = 2'd2,
        STATUS_CRC    = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_frame;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [15:0] first_word;
        logic [15:0] second_word;
    } t_out_item;

    // One byte through the CRC, eight shift steps unrolled.
    function automatic logic [15:0] crc_take_byte(input logic [15:0] crc_in,
                                                  input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

/* design/mrc_frame_tracker.sv */
// ----------------------------------------------------------------------------
// mrc_frame_tracker
// Per-frame state of the response checker: byte index, running CRC, header
// and CRC flags and the captured data words. Produces the result of a frame
// on the byte that ends it.
// ----------------------------------------------------------------------------
module mrc_frame_tracker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  mrc_pkg::t_in_item  i_item,
    input  logic               i_kind,
    output mrc_pkg::t_out_item o_result
);

    logic [3:0]  r_byte_index, n_byte_index;
    logic [15:0] r_running_crc, n_running_crc;
    logic        r_header_good, n_header_good;
    logic        r_crc_good, n_crc_good;
    logic [15:0] r_captured_first, n_captured_first;
    logic [15:0] r_captured_second, n_captured_second;

    logic [3:0]  payload_len;
    logic [4:0]  frame_len;
    logic [4:0]  count;
    logic [7:0]  b;
    logic [3:0]  i;

    always_comb begin
        b           = i_item.data_byte;
        i           = r_byte_index;
        payload_len = i_kind ? mrc_pkg::PAYLOAD_KIND1 : mrc_pkg::PAYLOAD_KIND0;
        frame_len   = {1'b0, payload_len} + 5'd2;
        count       = {1'b0, i} + 5'd1;

        n_header_good     = r_header_good;
        n_crc_good        = r_crc_good;
        n_running_crc     = r_running_crc;
        n_captured_first  = r_captured_first;
        n_captured_second = r_captured_second;

        if (i == mrc_pkg::IDX_SLAVE && b != mrc_pkg::HDR_SLAVE) begin
            n_header_good = 1'b0;
        end
        if (i == mrc_pkg::IDX_FUNC && b != mrc_pkg::HDR_FUNC) begin
            n_header_good = 1'b0;
        end
        if (i == mrc_pkg::IDX_COUNT &&
            b != (i_kind ? mrc_pkg::HDR_COUNT_KIND1 : mrc_pkg::HDR_COUNT_KIND0)) begin
            n_header_good = 1'b0;
        end

        if (i == mrc_pkg::IDX_DATA0) begin
            n_captured_first[15:8] = b;
        end
        if (i == mrc_pkg::IDX_DATA1) begin
            n_captured_first[7:0] = b;
        end
        if (i_kind && i == mrc_pkg::IDX_DATA2) begin
            n_captured_second[15:8] = b;
        end
        if (i_kind && i == mrc_pkg::IDX_DATA3) begin
            n_captured_second[7:0] = b;
        end

        // The CRC runs over the payload, then its low and high bytes are compared.
        if (i < payload_len) begin
            n_running_crc = mrc_pkg::crc_take_byte(r_running_crc, b);
        end else if (i == payload_len) begin
            if (b != r_running_crc[7:0]) begin
                n_crc_good = 1'b0;
            end
        end else if ({1'b0, i} == {1'b0, payload_len} + 5'd1) begin
            if (b != r_running_crc[15:8]) begin
                n_crc_good = 1'b0;
            end
        end

        n_byte_index = (i == mrc_pkg::IDX_MAX) ? i : count[3:0];

        if (count < frame_len) begin
            o_result.status = mrc_pkg::STATUS_SHORT;
        end else if (!n_header_good) begin
            o_result.status = mrc_pkg::STATUS_HEADER;
        end else if (!n_crc_good) begin
            o_result.status = mrc_pkg::STATUS_CRC;
        end else begin
            o_result.status = mrc_pkg::STATUS_VALID;
        end

        if (o_result.status == mrc_pkg::STATUS_VALID) begin
            o_result.first_word  = n_captured_first;
            o_result.second_word = i_kind ? n_captured_second : 16'h0000;
        end else begin
            o_result.first_word  = 16'h0000;
            o_result.second_word = 16'h0000;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index      <= '0;
            r_running_crc     <= mrc_pkg::CRC_INIT;
            r_header_good     <= 1'b1;
            r_crc_good        <= 1'b1;
            r_captured_first  <= '0;
            r_captured_second <= '0;
        end else if (i_take) begin
            if (i_item.end_of_frame) begin
                r_byte_index      <= '0;
                r_running_crc     <= mrc_pkg::CRC_INIT;
                r_header_good     <= 1'b1;
                r_crc_good        <= 1'b1;
                r_captured_first  <= '0;
                r_captured_second <= '0;
            end else begin
                r_byte_index      <= n_byte_index;
                r_running_crc     <= n_running_crc;
                r_header_good     <= n_header_good;
                r_crc_good        <= n_crc_good;
                r_captured_first  <= n_captured_first;
                r_captured_second <= n_captured_second;
            end
        end
    end

endmodule

/* design/modbus_response_checker_unit.sv */
// ----------------------------------------------------------------------------
// modbus_response_checker_unit
// Checks Modbus RTU read replies byte by byte and reports status and data.
// ----------------------------------------------------------------------------
// The block takes one response byte per input transaction, with end_of_frame
// set on the last byte, and returns one result transaction per frame: a
// status (valid, short frame, header mismatch or CRC mismatch, in that order
// of precedence with short first) and the two big-endian data words, which
// read as zero unless the frame is valid. The request kind register selects
// a 7-byte reply with one data word (kind 0) or a 9-byte reply with two
// (kind 1); write it only while no frame is in progress. A byte is accepted
// every clock cycle unless stalled: it is registered, then one pass of logic
// (the unrolled byte-wide CRC-16/MODBUS update and the header and CRC
// compares) updates the frame state and, on the last byte, loads the result
// register. The only stall is a frame's last byte meeting a result that has
// not yet been taken; ordinary bytes never wait on the output side. The last
// byte passes the input register, then the result register. Bytes past the
// CRC are ignored, and a new frame starts after every byte flagged as last.
// ----------------------------------------------------------------------------
module modbus_response_checker_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Byte input channel.
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mrc_pkg::t_in_item  i_in_data,
    // Result channel.
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output mrc_pkg::t_out_item o_out_data,
    // Request kind register write channel.
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data
);

    // Input register: holds one accepted byte until the frame logic takes it.
    logic               r_in_valid;
    mrc_pkg::t_in_item  r_in_item;

    // Result register.
    logic               r_out_valid;
    mrc_pkg::t_out_item r_out_item;

    logic               r_request_kind;

    logic               take;
    mrc_pkg::t_out_item result;

    // A byte that ends a frame needs a free result slot; others always pass.
    assign take        = r_in_valid &&
                         (!r_in_item.end_of_frame || !r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || take;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_request_kind <= 1'b0;
        end else if (i_cfg_valid) begin
            r_request_kind <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_data;
        end
    end

    mrc_frame_tracker u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_item   (r_in_item),
        .i_kind   (r_request_kind),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take && r_in_item.end_of_frame) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && r_in_item.end_of_frame) begin
            r_out_item <= result;
        end
    end

    // The input side only holds off while a byte is waiting in the register.
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_in_valid)
        else $error("input ready dropped with an empty input register");

    // A frame end taken by the frame logic always produces a result.
    a_frame_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && r_in_item.end_of_frame |=> o_out_valid)
        else $error("frame end did not produce a result");

    // Words read as zero on any result that is not valid.
    a_invalid_words_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != mrc_pkg::STATUS_VALID |->
            o_out_data.first_word == 16'h0000 && o_out_data.second_word == 16'h0000)
        else $error("nonzero data words on a failed frame");

endmodule

/* sim/modbus_response_checker_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_response_checker_unit_tb
// Self-checking bench for the Modbus RTU read-reply checker.
// ----------------------------------------------------------------------------
// Response bytes are pushed through the byte channel with random gaps while
// the result channel stalls at random. Every accepted byte is run through a
// behavioral copy of the reply checker, and every frame end leaves one
// expected result in a queue. Each result transaction is checked field by
// field against the oldest queued result. The run covers both request kinds,
// well-formed replies with random data, corrupted headers, data and CRC
// bytes, short and over-long frames, raw noise, a kind change in the middle
// of a frame and a long stall of the result channel.
// ----------------------------------------------------------------------------
module modbus_response_checker_unit_tb;

    localparam int CLK_HALF     = 10;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_BYTES = 630;

    // DUT connections; the inputs are driven to known values from time zero.
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    mrc_pkg::t_in_item  i_in_data   = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    mrc_pkg::t_out_item o_out_data;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic               i_cfg_data  = 1'b0;

    // Stimulus control.
    bit         tx_idle_on  = 1'b1;
    bit         rx_idle_on  = 1'b1;
    logic       active_kind = 1'b0;
    logic [7:0] frame_bytes[$];
    int         bytes_sent  = 0;

    // Result-side stall control. A long hold-off is timed by its own process.
    event       rx_hold_go;
    int         rx_hold_len = 0;
    logic       rx_hold     = 1'b0;
    int         rx_wait     = 0;
    int         rx_draw;

    // Behavioral copy of the checker: request kind plus the frame state.
    logic        model_kind = 1'b0;
    logic [3:0]  frm_pos    = 4'd0;
    logic [15:0] frm_crc    = mrc_pkg::CRC_INIT;
    logic        hdr_ok     = 1'b1;
    logic        crc_ok     = 1'b1;
    logic [15:0] word0      = 16'h0000;
    logic [15:0] word1      = 16'h0000;

    mrc_pkg::t_out_item expected_results[$];
    mrc_pkg::t_out_item want_result;
    int                 err_count   = 0;
    int                 cycle_count = 0;

    modbus_response_checker_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // CRC-16/MODBUS, one byte at a time, LSB first.
    function automatic logic [15:0] crc16_update(input logic [15:0] acc,
                                                 input logic [7:0]  b);
        logic [15:0] r;
        r = acc ^ {8'h00, b};
        repeat (8) r = r[0] ? ((r >> 1) ^ mrc_pkg::CRC_POLY) : (r >> 1);
        return r;
    endfunction

    task automatic clear_frame_state();
        frm_pos = 4'd0;
        frm_crc = mrc_pkg::CRC_INIT;
        hdr_ok  = 1'b1;
        crc_ok  = 1'b1;
        word0   = 16'h0000;
        word1   = 16'h0000;
    endtask

    // Takes one accepted byte. Each byte is judged against the kind in force
    // when it arrives, so the payload length is worked out per byte.
    task automatic absorb_byte(input mrc_pkg::t_in_item it);
        logic [7:0]         b;
        logic [3:0]         pos;
        logic [3:0]         data_len;
        logic [7:0]         want_count;
        int                 taken;
        mrc_pkg::t_out_item res;
        b          = it.data_byte;
        pos        = frm_pos;
        data_len   = model_kind ? mrc_pkg::PAYLOAD_KIND1 : mrc_pkg::PAYLOAD_KIND0;
        want_count = model_kind ? mrc_pkg::HDR_COUNT_KIND1 : mrc_pkg::HDR_COUNT_KIND0;

        if (pos == mrc_pkg::IDX_SLAVE && b != mrc_pkg::HDR_SLAVE) hdr_ok = 1'b0;
        if (pos == mrc_pkg::IDX_FUNC  && b != mrc_pkg::HDR_FUNC)  hdr_ok = 1'b0;
        if (pos == mrc_pkg::IDX_COUNT && b != want_count)         hdr_ok = 1'b0;

        if (pos == mrc_pkg::IDX_DATA0) word0[15:8] = b;
        if (pos == mrc_pkg::IDX_DATA1) word0[7:0]  = b;
        if (model_kind && pos == mrc_pkg::IDX_DATA2) word1[15:8] = b;
        if (model_kind && pos == mrc_pkg::IDX_DATA3) word1[7:0]  = b;

        // The CRC runs over header and data, then freezes for the compare.
        if (pos < data_len) begin
            frm_crc = crc16_update(frm_crc, b);
        end else if (pos == data_len) begin
            if (b != frm_crc[7:0]) crc_ok = 1'b0;
        end else if (pos == data_len + 4'd1) begin
            if (b != frm_crc[15:8]) crc_ok = 1'b0;
        end

        taken = int'(pos) + 1;
        if (pos != mrc_pkg::IDX_MAX) frm_pos = pos + 4'd1;

        if (it.end_of_frame) begin
            res = '0;
            if (taken < int'(data_len) + 2) begin
                res.status = mrc_pkg::STATUS_SHORT;
            end else if (!hdr_ok) begin
                res.status = mrc_pkg::STATUS_HEADER;
            end else if (!crc_ok) begin
                res.status = mrc_pkg::STATUS_CRC;
            end else begin
                res.status      = mrc_pkg::STATUS_VALID;
                res.first_word  = word0;
                res.second_word = model_kind ? word1 : 16'h0000;
            end
            expected_results.push_back(res);
            clear_frame_state();
        end
    endtask

    // Watches both write channels and feeds the predictor.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) model_kind = i_cfg_data;
            if (i_in_valid && o_in_ready) absorb_byte(i_in_data);
        end
    end

    // ------------------------------------------------------------------------
    // Result channel: random stalls, long hold-off, checking
    // ------------------------------------------------------------------------

    always begin
        @(rx_hold_go);
        rx_hold <= 1'b1;
        repeat (rx_hold_len) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // After each result transaction the receiver draws how long to wait.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rx_wait     <= 0;
        end else if (rx_hold) begin
            i_out_ready <= 1'b0;
        end else if (o_out_valid && i_out_ready) begin
            rx_draw = rx_idle_on ? $urandom_range(0, 7) : 0;
            rx_wait     <= rx_draw;
            i_out_ready <= (rx_draw == 0);
        end else if (rx_wait > 0) begin
            rx_wait     <= rx_wait - 1;
            i_out_ready <= (rx_wait == 1);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with none expected, actual %h", $time, o_out_data);
                err_count++;
            end else begin
                want_result = expected_results.pop_front();
                if (o_out_data.status != want_result.status) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want_result.status, o_out_data.status);
                    err_count++;
                end
                if (o_out_data.first_word != want_result.first_word) begin
                    $display("%0t: first_word mismatch, expected %h, actual %h",
                             $time, want_result.first_word, o_out_data.first_word);
                    err_count++;
                end
                if (o_out_data.second_word != want_result.second_word) begin
                    $display("%0t: second_word mismatch, expected %h, actual %h",
                             $time, want_result.second_word, o_out_data.second_word);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still expected", $time,
                     expected_results.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Shared stimulus tasks
    // ------------------------------------------------------------------------

    // Offers one byte after a random gap and returns at the edge where the
    // transaction happens. Valid is left high so that a back-to-back byte
    // needs only a payload update.
    task automatic send_byte(input logic [7:0] b, input logic eof);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{data_byte: b, end_of_frame: eof};
        do @(posedge i_clk); while (!o_in_ready);
        bytes_sent++;
    endtask

    // Sends frame_bytes[from..to]; the last one carries the frame end if asked.
    task automatic send_frame_part(input int from, input int to, input bit close);
        for (int k = from; k <= to; k++) begin
            send_byte(frame_bytes[k], close && (k == to));
        end
    endtask

    // Stops offering bytes and waits until every expected result has been
    // taken, plus enough cycles for a byte that causes no result to retire.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_kind(input logic kind);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= kind;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        active_kind = kind;
    endtask

    // Builds a well-formed reply with a correct CRC into frame_bytes. The
    // byte count is passed in so that deliberately odd headers stay possible.
    task automatic build_reply(input logic kind, input logic [7:0] count_byte,
                               input logic [15:0] w0, input logic [15:0] w1);
        logic [15:0] crc;
        frame_bytes = {};
        frame_bytes.push_back(mrc_pkg::HDR_SLAVE);
        frame_bytes.push_back(mrc_pkg::HDR_FUNC);
        frame_bytes.push_back(count_byte);
        frame_bytes.push_back(w0[15:8]);
        frame_bytes.push_back(w0[7:0]);
        if (kind) begin
            frame_bytes.push_back(w1[15:8]);
            frame_bytes.push_back(w1[7:0]);
        end
        crc = mrc_pkg::CRC_INIT;
        foreach (frame_bytes[k]) crc = crc16_update(crc, frame_bytes[k]);
        frame_bytes.push_back(crc[7:0]);
        frame_bytes.push_back(crc[15:8]);
    endtask

    function automatic logic [15:0] random_word();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [7:0] random_flip();
        return 8'($urandom_range(1, 255));
    endfunction

    // One frame of the random mix: mostly well-formed replies with random
    // data, the rest damaged in one place, cut short, padded or pure noise.
    task automatic send_random_frame();
        int         pick;
        int         pos;
        int         cut;
        int         n;
        logic       build_kind;
        logic [7:0] count_byte;
        pick       = $urandom_range(0, 99);
        build_kind = ($urandom_range(0, 19) == 0) ? ~active_kind : active_kind;
        count_byte = build_kind ? mrc_pkg::HDR_COUNT_KIND1 : mrc_pkg::HDR_COUNT_KIND0;
        build_reply(build_kind, count_byte, random_word(), random_word());
        if (pick < 55) begin
            send_frame_part(0, frame_bytes.size() - 1, 1'b1);
        end else if (pick < 63) begin
            pos = $urandom_range(0, 2);
            frame_bytes[pos] ^= random_flip();
            send_frame_part(0, frame_bytes.size() - 1, 1'b1);
        end else if (pick < 71) begin
            pos = frame_bytes.size() - 1 - $urandom_range(0, 1);
            frame_bytes[pos] ^= random_flip();
            send_frame_part(0, frame_bytes.size() - 1, 1'b1);
        end else if (pick < 77) begin
            // A damaged data byte leaves the header intact but breaks the CRC.
            pos = $urandom_range(3, frame_bytes.size() - 3);
            frame_bytes[pos] ^= random_flip();
            send_frame_part(0, frame_bytes.size() - 1, 1'b1);
        end else if (pick < 85) begin
            cut = $urandom_range(1, frame_bytes.size() - 1);
            send_frame_part(0, cut - 1, 1'b1);
        end else if (pick < 92) begin
            repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom_range(0, 255)));
            send_frame_part(0, frame_bytes.size() - 1, 1'b1);
        end else begin
            // Noise: random bytes with frame ends scattered among them.
            n = $urandom_range(1, 16);
            for (int k = 0; k < n; k++) begin
                send_byte(8'($urandom_range(0, 255)),
                          (k == n - 1) || ($urandom_range(0, 3) == 0));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Kind 0 straight out of reset, with all-ones data.
    task automatic test_kind0_reply();
        build_reply(1'b0, mrc_pkg::HDR_COUNT_KIND0, 16'hFFFF, 16'h0000);
        send_frame_part(0, frame_bytes.size() - 1, 1'b1);
    endtask

    // Short beats header, header beats CRC, and a lone CRC error.
    task automatic test_status_precedence();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        build_reply(1'b0, mrc_pkg::HDR_COUNT_KIND0, 16'h1234, 16'h0000);
        frame_bytes[1] = 8'h83;
        frame_bytes[6] ^= 8'hFF;
        send_frame_part(0, frame_bytes.size() - 1, 1'b1);
        build_reply(1'b0, mrc_pkg::HDR_COUNT_KIND0, 16'h0000, 16'h0000);
        frame_bytes[5] ^= 8'h01;
        send_frame_part(0, frame_bytes.size() - 1, 1'b1);
    endtask

    // Kind 1 reply followed by enough junk to pin the byte index at its top.
    task automatic test_trailing_bytes();
        wait_idle();
        write_kind(1'b1);
        build_reply(1'b1, mrc_pkg::HDR_COUNT_KIND1, 16'h0000, 16'hFFFF);
        repeat (8) frame_bytes.push_back(8'($urandom_range(0, 255)));
        send_frame_part(0, frame_bytes.size() - 1, 1'b1);
    endtask

    // Header taken under kind 0, data and CRC under kind 1: a valid 9-byte
    // reply whose count byte says two.
    task automatic test_kind_change_mid_frame();
        wait_idle();
        write_kind(1'b0);
        build_reply(1'b1, mrc_pkg::HDR_COUNT_KIND0, random_word(), random_word());
        send_frame_part(0, 2, 1'b0);
        wait_idle();
        write_kind(1'b1);
        send_frame_part(3, frame_bytes.size() - 1, 1'b1);
    endtask

    // The result side holds off while the sender keeps offering frame ends,
    // so the result register fills and the byte channel has to stall.
    task automatic test_result_backpressure();
        wait_idle();
        tx_idle_on  = 1'b0;
        rx_hold_len = 150;
        -> rx_hold_go;
        repeat (10) send_byte(8'($urandom_range(0, 255)), 1'b1);
        build_reply(active_kind,
                    active_kind ? mrc_pkg::HDR_COUNT_KIND1 : mrc_pkg::HDR_COUNT_KIND0,
                    random_word(), random_word());
        send_frame_part(0, frame_bytes.size() - 1, 1'b1);
        wait_idle();
        tx_idle_on = 1'b1;
    endtask

    // Phases of random frames; between phases the bench drains, picks a new
    // kind and new idle behavior for both sides.
    task automatic test_random_traffic();
        int target;
        target = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < target) begin
            wait_idle();
            write_kind(1'($urandom_range(0, 1)));
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(5, 20)) send_random_frame();
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_kind0_reply();
        test_status_precedence();
        test_trailing_bytes();
        test_kind_change_mid_frame();
        test_result_backpressure();
        test_random_traffic();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
